// File: hdl/srgb_to_cielab_unit_defines.svh
// Assertion macros used by srgb_to_cielab_unit.sv.
`ifndef SRGB_TO_CIELAB_UNIT_DEFINES_SVH
`define SRGB_TO_CIELAB_UNIT_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define S2L_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked outside reset.
`define S2L_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: hdl/s2l_pkg.sv
package s2l_pkg;

   // Output format
   localparam int FRACTION_BITS = 8;
   localparam int QB = 30;
   localparam int ROUND_SHIFT = QB - FRACTION_BITS;
   localparam int LMAX_RAW = 100 << FRACTION_BITS;
   localparam int LMAX = (LMAX_RAW > 32767) ? 32767 : LMAX_RAW;

   // Datapath widths
   localparam int LIN_W = 31;
   localparam int PROD_W = 45;
   localparam int SUM_W = 47;
   localparam int NUM_W = 48;
   localparam int RECIP_W = 36;
   localparam int RECIP_SHIFT = 47;
   localparam int DIV_W = 17;
   localparam int QUOT_W = 32;
   localparam int ROOT_W = 31;
   localparam int ROOT_STEPS = ROOT_W;
   localparam int ACC_W = 43;

   // Pipeline depths
   localparam int CDIV_LAT = 4;
   localparam int CBRT_LAT = 3 * ROOT_STEPS;
   localparam int LIN_DLY = CBRT_LAT - CDIV_LAT;
   localparam int PIPE_DEPTH = 3 + CDIV_LAT + 1 + CBRT_LAT + 3;

   // sRGB-to-XYZ matrix rows (x, y, z), scale and rounding per row
   typedef logic [13:0] coef_row_type [3];
   typedef logic [13:0] coef_mtx_type [3][3];
   localparam coef_mtx_type MTX = '{'{14'd4124, 14'd3576, 14'd1805},
                                    '{14'd2126, 14'd7152, 14'd722},
                                    '{14'd193,  14'd1192, 14'd9505}};
   typedef logic [3:0] scale_vec_type [3];
   localparam scale_vec_type ROW_SCALE = '{4'd10, 4'd1, 4'd10};
   typedef logic [DIV_W-1:0] div_vec_type [3];
   localparam div_vec_type ROW_HALF = '{17'd47523, 17'd5000, 17'd54441};
   localparam div_vec_type ROW_DIV = '{17'd95047, 17'd10000, 17'd108883};
   typedef logic [RECIP_W-1:0] recip_vec_type [3];
   localparam logic [63:0] RECIP_ONE = 64'd1 << RECIP_SHIFT;
   localparam recip_vec_type ROW_RECIP = '{RECIP_W'(RECIP_ONE / 64'd95047),
                                           RECIP_W'(RECIP_ONE / 64'd10000),
                                           RECIP_W'(RECIP_ONE / 64'd108883)};

   // Lab f linear segment and knee
   localparam logic [14:0] LAB_SLOPE = 15'd24389;
   localparam logic [NUM_W-1:0] LAB_OFS = NUM_W'((64'd432 << QB) + 64'd1566);
   localparam logic [DIV_W-1:0] LAB_DIV = 17'd3132;
   localparam logic [RECIP_W-1:0] LAB_RECIP = RECIP_W'(RECIP_ONE / 64'd3132);
   localparam logic [QUOT_W-1:0] LAB_KNEE = QUOT_W'((64'd8856 << QB) / 64'd1000000);

   // Q30 power with truncated products
   function automatic logic [63:0] qpow_f(logic [63:0] y, int n);
      logic [63:0] p;
      p = y;
      for (int i = 1; i < n; i++) begin
         p = (p * y) >> QB;
      end
      return p;
   endfunction

   // Largest y in [0, hi] with qpow_f(y, n) <= target
   function automatic logic [63:0] qroot_f(logic [63:0] target, int n, logic [63:0] hi);
      logic [63:0] lo;
      logic [63:0] top;
      logic [63:0] mid;
      lo = 64'd0;
      top = hi;
      for (int k = 0; k < 64; k++) begin
         if (lo < top) begin
            mid = (lo + top + 64'd1) >> 1;
            if (qpow_f(mid, n) <= target) begin
               lo = mid;
            end else begin
               top = mid - 64'd1;
            end
         end
      end
      return lo;
   endfunction

   // sRGB transfer curve in Q30
   function automatic logic [63:0] linearize_f(logic [63:0] c);
      logic [63:0] t;
      logic [63:0] t2;
      logic [63:0] w;
      logic [63:0] res;
      if (c <= 64'd10) begin
         res = (((c * 64'd100) << QB) + 64'd164730) / 64'd329460;
      end else begin
         t = (((64'd1000 * c + 64'd14025) << QB) + 64'd134512) / 64'd269025;
         t2 = (t * t + (64'd1 << (QB - 1))) >> QB;
         w = qroot_f(t2, 5, 64'd1 << QB);
         res = (t2 * w + (64'd1 << (QB - 1))) >> QB;
      end
      return res;
   endfunction

   typedef logic [LIN_W-1:0] lin_table_type [256];

   function automatic lin_table_type build_lin_table();
      lin_table_type tbl;
      for (int c = 0; c < 256; c++) begin
         tbl[c] = LIN_W'(linearize_f(64'(c)));
      end
      return tbl;
   endfunction

   localparam lin_table_type LIN_TABLE = build_lin_table();

endpackage

// File: hdl/s2l_cdiv.sv
// Round-free division by a constant: reciprocal multiply, one-step fixup.
module s2l_cdiv (
   input  logic                          clock,
   input  logic                          enable,
   input  logic [s2l_pkg::NUM_W-1:0]     num,
   input  logic [s2l_pkg::RECIP_W-1:0]   recip,
   input  logic [s2l_pkg::DIV_W-1:0]     divisor,
   output logic [s2l_pkg::QUOT_W-1:0]    quot
);
   import s2l_pkg::*;

   localparam int HALF_W = NUM_W / 2;
   localparam int PP_W = HALF_W + RECIP_W;
   localparam int SUM_ACC_W = PP_W + HALF_W + 1;
   localparam int PD_W = QUOT_W + DIV_W;

   logic [NUM_W-1:0]     n1_ff, n2_ff, n3_ff;
   logic [PP_W-1:0]      ph_ff, pl_ff, ph_in, pl_in;
   logic [SUM_ACC_W-1:0] acc;
   logic [QUOT_W-1:0]    qe_ff, qe_in, q3_ff, q_ff, q_in;
   logic [PD_W-1:0]      pd_ff, pd_in;
   logic [NUM_W-1:0]     rem;

   // partial products of num * recip
   assign ph_in = PP_W'(num[NUM_W-1:HALF_W]) * PP_W'(recip);
   assign pl_in = PP_W'(num[HALF_W-1:0]) * PP_W'(recip);

   // estimate, low by at most one
   assign acc = {1'b0, ph_ff, {HALF_W{1'b0}}} + SUM_ACC_W'(pl_ff);
   assign qe_in = acc[RECIP_SHIFT +: QUOT_W];

   assign pd_in = PD_W'(qe_ff) * PD_W'(divisor);

   // fixup on the remainder
   assign rem = n3_ff - NUM_W'(pd_ff);
   assign q_in = (rem >= NUM_W'(divisor)) ? q3_ff + QUOT_W'(1) : q3_ff;

   always_ff @(posedge clock) begin
      if (enable) begin
         n1_ff <= num;
         ph_ff <= ph_in;
         pl_ff <= pl_in;
         n2_ff <= n1_ff;
         qe_ff <= qe_in;
         n3_ff <= n2_ff;
         q3_ff <= qe_ff;
         pd_ff <= pd_in;
         q_ff  <= q_in;
      end
   end

   assign quot = q_ff;

endmodule

// File: hdl/s2l_labf.sv
// Lab f: bit-serial cube root pipeline, linear segment below the knee.
module s2l_labf (
   input  logic                        clock,
   input  logic                        enable,
   input  logic [s2l_pkg::QUOT_W-1:0]  ratio,
   output logic [s2l_pkg::QUOT_W-1:0]  f_value
);
   import s2l_pkg::*;

   localparam int SQ_W = 2 * ROOT_W;
   localparam int CUBE_W = 2 * ROOT_W + 1;
   localparam int CMP_W = CUBE_W - QB;

   logic [QUOT_W-1:0] v_ff;
   logic              knee_ff, knee_in;
   logic [NUM_W-1:0]  nlin_ff, nlin_in;
   logic [QUOT_W-1:0] lin_q;

   // entry stage: branch flag and linear-segment numerator
   assign knee_in = (ratio > LAB_KNEE);
   assign nlin_in = NUM_W'(39'(LAB_SLOPE) * 39'(ratio[23:0])) + LAB_OFS;

   always_ff @(posedge clock) begin
      if (enable) begin
         v_ff    <= ratio;
         knee_ff <= knee_in;
         nlin_ff <= nlin_in;
      end
   end

   s2l_cdiv u_lin_div (
      .clock   (clock),
      .enable  (enable),
      .num     (nlin_ff),
      .recip   (LAB_RECIP),
      .divisor (LAB_DIV),
      .quot    (lin_q)
   );

   // cube root, one bit per three stages, MSB first
   logic [ROOT_W-1:0] y_chain [ROOT_STEPS+1];
   logic [QUOT_W-1:0] v_chain [ROOT_STEPS+1];

   assign y_chain[0] = '0;
   assign v_chain[0] = v_ff;

   for (genvar s = 0; s < ROOT_STEPS; s++) begin : g_step
      localparam logic [ROOT_W-1:0] STEP_BIT = ROOT_W'(1) << (ROOT_W - 1 - s);

      logic [ROOT_W-1:0] cand_in;
      logic [SQ_W-1:0]   sq_in, a_sq_ff;
      logic [ROOT_W-1:0] a_cand_ff, a_y_ff, b_cand_ff, b_y_ff, c_y_ff, y_in;
      logic [QUOT_W-1:0] a_v_ff, b_v_ff, c_v_ff;
      logic [CUBE_W-1:0] cube_in, b_cube_ff;

      assign cand_in = y_chain[s] | STEP_BIT;
      assign sq_in = SQ_W'(cand_in) * SQ_W'(cand_in);
      assign cube_in = CUBE_W'(a_sq_ff[SQ_W-1:QB]) * CUBE_W'(a_cand_ff);
      assign y_in = (b_cube_ff[CUBE_W-1:QB] <= CMP_W'(b_v_ff)) ? b_cand_ff : b_y_ff;

      always_ff @(posedge clock) begin
         if (enable) begin
            a_sq_ff   <= sq_in;
            a_cand_ff <= cand_in;
            a_y_ff    <= y_chain[s];
            a_v_ff    <= v_chain[s];
            b_cube_ff <= cube_in;
            b_cand_ff <= a_cand_ff;
            b_y_ff    <= a_y_ff;
            b_v_ff    <= a_v_ff;
            c_y_ff    <= y_in;
            c_v_ff    <= b_v_ff;
         end
      end

      assign y_chain[s+1] = c_y_ff;
      assign v_chain[s+1] = c_v_ff;
   end

   // line up the linear result and branch flag with the root
   logic [QUOT_W-1:0] lin_dly_ff [LIN_DLY];
   logic [CBRT_LAT-1:0] knee_dly_ff;

   always_ff @(posedge clock) begin
      if (enable) begin
         lin_dly_ff[0] <= lin_q;
         for (int i = 1; i < LIN_DLY; i++) begin
            lin_dly_ff[i] <= lin_dly_ff[i-1];
         end
         knee_dly_ff <= {knee_dly_ff[CBRT_LAT-2:0], knee_ff};
      end
   end

   assign f_value = knee_dly_ff[CBRT_LAT-1] ? QUOT_W'(y_chain[ROOT_STEPS])
                                            : lin_dly_ff[LIN_DLY-1];

endmodule

// File: hdl/srgb_to_cielab_unit.sv
// Throughput: one item per cycle unless rsp stalls; the depth comes from the
// Lab f cube root, three stages per result bit over 31 bits, run for all three
// channels at once. A stall on rsp while rsp_valid is high holds the whole
// pipeline; req_stall follows it in the same cycle.
// Reset clears only the valid bits; data registers are not reset.
`include "srgb_to_cielab_unit_defines.svh"

module srgb_to_cielab_unit (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [7:0]         req_red_in,
   input  logic [7:0]         req_green_in,
   input  logic [7:0]         req_blue_in,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [14:0]        rsp_lightness,
   output logic signed [15:0] rsp_green_red_axis,
   output logic signed [15:0] rsp_blue_yellow_axis
);
   import s2l_pkg::*;

   logic enable;
   logic [PIPE_DEPTH-1:0] valid_pipe_ff, valid_pipe_in;
   logic rsp_valid_ff, rsp_valid_in;

   // global advance: blocked only by an output item that is not taken
   assign enable = !rsp_valid_ff || !rsp_stall;
   assign req_stall = !enable;

   assign valid_pipe_in = {valid_pipe_ff[PIPE_DEPTH-2:0], req_valid};
   assign rsp_valid_in = valid_pipe_ff[PIPE_DEPTH-1];

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_pipe_ff <= '0;
         rsp_valid_ff  <= 1'b0;
      end else if (enable) begin
         valid_pipe_ff <= valid_pipe_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // stage 1: transfer curve lookup
   logic [LIN_W-1:0] lin_ff [3];

   always_ff @(posedge clock) begin
      if (enable) begin
         lin_ff[0] <= LIN_TABLE[req_red_in];
         lin_ff[1] <= LIN_TABLE[req_green_in];
         lin_ff[2] <= LIN_TABLE[req_blue_in];
      end
   end

   // stages 2..: matrix row, divide by white point, Lab f
   logic [QUOT_W-1:0] f_val [3];

   for (genvar ch = 0; ch < 3; ch++) begin : g_row
      logic [PROD_W-1:0] prod_ff [3];
      logic [SUM_W-1:0]  row_sum;
      logic [NUM_W-1:0]  num_ff, num_in;
      logic [QUOT_W-1:0] ratio;

      always_ff @(posedge clock) begin
         if (enable) begin
            for (int k = 0; k < 3; k++) begin
               prod_ff[k] <= PROD_W'(MTX[ch][k]) * PROD_W'(lin_ff[k]);
            end
            num_ff <= num_in;
         end
      end

      assign row_sum = SUM_W'(prod_ff[0]) + SUM_W'(prod_ff[1]) + SUM_W'(prod_ff[2]);
      assign num_in = NUM_W'(row_sum) * NUM_W'(ROW_SCALE[ch]) + NUM_W'(ROW_HALF[ch]);

      s2l_cdiv u_div (
         .clock   (clock),
         .enable  (enable),
         .num     (num_ff),
         .recip   (ROW_RECIP[ch]),
         .divisor (ROW_DIV[ch]),
         .quot    (ratio)
      );

      s2l_labf u_labf (
         .clock   (clock),
         .enable  (enable),
         .ratio   (ratio),
         .f_value (f_val[ch])
      );
   end

   // L, a, b in Q30
   logic [QUOT_W-1:0] fx_ff, fy_ff, fz_ff;
   logic signed [ACC_W-1:0] fx_s, fy_s, fz_s;
   logic signed [ACC_W-1:0] lq_ff, aq_ff, bq_ff, lq_in, aq_in, bq_in;

   assign fx_s = signed'(ACC_W'(fx_ff));
   assign fy_s = signed'(ACC_W'(fy_ff));
   assign fz_s = signed'(ACC_W'(fz_ff));
   assign lq_in = ACC_W'(116) * fy_s - (signed'(ACC_W'(16)) <<< QB);
   assign aq_in = ACC_W'(500) * (fx_s - fy_s);
   assign bq_in = ACC_W'(200) * (fy_s - fz_s);

   // round half away from zero
   function automatic logic signed [ACC_W-1:0] round_out(logic signed [ACC_W-1:0] v);
      logic [ACC_W-1:0] mag;
      mag = v[ACC_W-1] ? ACC_W'(-v) : ACC_W'(v);
      mag = (mag + (ACC_W'(1) << (ROUND_SHIFT - 1))) >> ROUND_SHIFT;
      return v[ACC_W-1] ? -signed'(mag) : signed'(mag);
   endfunction

   logic signed [ACC_W-1:0] lr_ff, ar_ff, br_ff;

   // saturate
   function automatic logic signed [15:0] sat16(logic signed [ACC_W-1:0] v);
      logic signed [15:0] res;
      if (v < -ACC_W'(32768)) begin
         res = 16'sh8000;
      end else if (v > ACC_W'(32767)) begin
         res = 16'sh7FFF;
      end else begin
         res = v[15:0];
      end
      return res;
   endfunction

   logic [14:0] l_in;
   assign l_in = (lr_ff < 0) ? 15'd0 :
                 (lr_ff > ACC_W'(LMAX)) ? 15'(LMAX) : lr_ff[14:0];

   logic [14:0] l_ff;
   logic signed [15:0] a_ff, b_ff;

   always_ff @(posedge clock) begin
      if (enable) begin
         fx_ff <= f_val[0];
         fy_ff <= f_val[1];
         fz_ff <= f_val[2];
         lq_ff <= lq_in;
         aq_ff <= aq_in;
         bq_ff <= bq_in;
         lr_ff <= round_out(lq_ff);
         ar_ff <= round_out(aq_ff);
         br_ff <= round_out(bq_ff);
         l_ff  <= l_in;
         a_ff  <= sat16(ar_ff);
         b_ff  <= sat16(br_ff);
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_lightness = l_ff;
   assign rsp_green_red_axis = a_ff;
   assign rsp_blue_yellow_axis = b_ff;

   // checks
   `S2L_ASSERT_NOW(a_stall_cause, req_stall, rsp_valid_ff && rsp_stall,
                   "input stalled without output backpressure")
   `S2L_ASSERT_NOW(a_l_range, rsp_valid_ff, rsp_lightness <= 15'(LMAX),
                   "lightness above range")
   `S2L_ASSERT_NOW(a_rsp_source, $rose(rsp_valid_ff), $past(valid_pipe_ff[PIPE_DEPTH-1]),
                   "result without item in last stage")
   `S2L_ASSERT_NEXT(a_hold, rsp_valid_ff && rsp_stall, valid_pipe_ff == $past(valid_pipe_ff),
                    "pipeline moved under stall")

endmodule
